// ----- hw/rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and codes shared by the I2C register master sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_SREAD  = 3'd1;
  localparam logic [2:0] OP_SWRITE = 3'd2;
  localparam logic [2:0] OP_BWRITE = 3'd3;
  localparam logic [2:0] OP_BREAD  = 3'd4;
  localparam logic [2:0] OP_SUPPLY = 3'd5;

  localparam logic [7:0] READ_BIT  = 8'h01;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3,
    PH_TX_D, PH_TX_H, PH_TX_L,
    PH_AK_D, PH_AK_H, PH_AK_L,
    PH_WAIT,
    PH_RX_R, PH_RX_H, PH_RX_L,
    PH_MA_D, PH_MA_H, PH_MA_L,
    PH_SP0, PH_SP1, PH_SP2
  } phase_t;

  typedef enum logic [1:0] {
    SEG_DEV, SEG_REG, SEG_DATA, SEG_RDEV
  } seg_t;

  typedef enum logic [1:0] {
    KIND_SREAD, KIND_SWRITE, KIND_BWRITE, KIND_BREAD
  } kind_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] data_byte;
    logic [7:0] byte_count;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_data;
    logic       read_valid;
    logic       data_request;
    logic       ack_level;
    logic       busy_res;
    logic       done_res;
  } rsp_t;

  typedef struct packed {
    phase_t     phase;
    kind_t      op_kind;
    logic [2:0] bit_index;
    logic [7:0] shift_byte;
    logic [7:0] bytes_left;
    logic [7:0] held_dev_addr;
    logic [7:0] held_reg_addr;
    logic       scl_reg;
    logic       sda_reg;
    seg_t       seg;
    logic       ack_reg;
  } seq_state_t;

endpackage

// ----- hw/rtl/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq
// Sequencer state and one pin step of logic per item.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            step_en,
  input  i2cm_pkg::cmd_t  item,
  output i2cm_pkg::rsp_t  result
);

  i2cm_pkg::seq_state_t st;
  i2cm_pkg::seq_state_t st_next;
  logic                 rd_valid;
  logic                 stop_done;
  logic [7:0]           tx_byte;
  logic [2:0]           bit_pos;

  function automatic i2cm_pkg::seq_state_t after_write(input i2cm_pkg::seq_state_t s);
    i2cm_pkg::seq_state_t r;
    r = s;
    if (s.bytes_left == 8'd0) begin
      r.phase = i2cm_pkg::PH_SP0;
    end else if (s.op_kind == i2cm_pkg::KIND_BWRITE) begin
      r.phase = i2cm_pkg::PH_WAIT;
    end else begin
      r.bytes_left = s.bytes_left - 8'd1;
      r.seg        = i2cm_pkg::SEG_DATA;
      r.bit_index  = 3'd0;
      r.phase      = i2cm_pkg::PH_TX_D;
    end
    return r;
  endfunction

  always_comb begin
    case (st.seg)
      i2cm_pkg::SEG_DEV:  tx_byte = st.held_dev_addr;
      i2cm_pkg::SEG_REG:  tx_byte = st.held_reg_addr;
      i2cm_pkg::SEG_DATA: tx_byte = st.shift_byte;
      default:            tx_byte = st.held_dev_addr | i2cm_pkg::READ_BIT;
    endcase
  end

  assign bit_pos = 3'd7 - st.bit_index;

  always_comb begin
    st_next   = st;
    rd_valid  = 1'b0;
    stop_done = 1'b0;
    unique case (item.opcode)
      i2cm_pkg::OP_SREAD, i2cm_pkg::OP_SWRITE,
      i2cm_pkg::OP_BWRITE, i2cm_pkg::OP_BREAD: begin
        if (st.phase == i2cm_pkg::PH_IDLE) begin
          st_next.op_kind       = i2cm_pkg::kind_t'(item.opcode[1:0] - 2'd1);
          st_next.held_dev_addr = item.dev_addr;
          st_next.held_reg_addr = item.reg_addr;
          st_next.shift_byte    = (item.opcode == i2cm_pkg::OP_SWRITE) ? item.data_byte : 8'd0;
          st_next.bytes_left    = (item.opcode == i2cm_pkg::OP_SREAD ||
                                   item.opcode == i2cm_pkg::OP_SWRITE) ? 8'd1 : item.byte_count;
          st_next.seg           = i2cm_pkg::SEG_DEV;
          st_next.bit_index     = 3'd0;
          st_next.phase         = i2cm_pkg::PH_ST0;
        end
      end
      i2cm_pkg::OP_SUPPLY: begin
        if (st.phase == i2cm_pkg::PH_WAIT) begin
          st_next.shift_byte = item.data_byte;
          st_next.bytes_left = st.bytes_left - 8'd1;
          st_next.seg        = i2cm_pkg::SEG_DATA;
          st_next.bit_index  = 3'd0;
          st_next.phase      = i2cm_pkg::PH_TX_D;
        end
      end
      i2cm_pkg::OP_TICK: begin
        unique case (st.phase)
          i2cm_pkg::PH_ST0: begin
            st_next.sda_reg = 1'b1;
            st_next.phase   = i2cm_pkg::PH_ST1;
          end
          i2cm_pkg::PH_ST1: begin
            st_next.scl_reg = 1'b1;
            st_next.phase   = i2cm_pkg::PH_ST2;
          end
          i2cm_pkg::PH_ST2: begin
            st_next.sda_reg = 1'b0;
            st_next.phase   = i2cm_pkg::PH_ST3;
          end
          i2cm_pkg::PH_ST3: begin
            st_next.scl_reg   = 1'b0;
            st_next.bit_index = 3'd0;
            st_next.phase     = i2cm_pkg::PH_TX_D;
          end
          i2cm_pkg::PH_TX_D: begin
            st_next.sda_reg = tx_byte[bit_pos];
            st_next.phase   = i2cm_pkg::PH_TX_H;
          end
          i2cm_pkg::PH_TX_H: begin
            st_next.scl_reg = 1'b1;
            st_next.phase   = i2cm_pkg::PH_TX_L;
          end
          i2cm_pkg::PH_TX_L: begin
            st_next.scl_reg = 1'b0;
            if (st.bit_index == 3'd7) begin
              st_next.phase = i2cm_pkg::PH_AK_D;
            end else begin
              st_next.bit_index = st.bit_index + 3'd1;
              st_next.phase     = i2cm_pkg::PH_TX_D;
            end
          end
          i2cm_pkg::PH_AK_D: begin
            st_next.sda_reg = 1'b1;
            st_next.phase   = i2cm_pkg::PH_AK_H;
          end
          i2cm_pkg::PH_AK_H: begin
            st_next.scl_reg = 1'b1;
            st_next.phase   = i2cm_pkg::PH_AK_L;
          end
          i2cm_pkg::PH_AK_L: begin
            st_next.scl_reg = 1'b0;
            st_next.ack_reg = item.sda_sample;
            unique case (st.seg)
              i2cm_pkg::SEG_DEV: begin
                st_next.seg       = i2cm_pkg::SEG_REG;
                st_next.bit_index = 3'd0;
                st_next.phase     = i2cm_pkg::PH_TX_D;
              end
              i2cm_pkg::SEG_REG: begin
                if (st.op_kind == i2cm_pkg::KIND_SREAD ||
                    st.op_kind == i2cm_pkg::KIND_BREAD) begin
                  st_next.seg   = i2cm_pkg::SEG_RDEV;
                  st_next.phase = i2cm_pkg::PH_ST0;
                end else begin
                  st_next = after_write(st_next);
                end
              end
              i2cm_pkg::SEG_DATA: begin
                st_next = after_write(st_next);
              end
              default: begin
                st_next.phase = (st.bytes_left == 8'd0) ? i2cm_pkg::PH_SP0
                                                        : i2cm_pkg::PH_RX_R;
              end
            endcase
          end
          i2cm_pkg::PH_RX_R: begin
            st_next.sda_reg    = 1'b1;
            st_next.shift_byte = 8'd0;
            st_next.bit_index  = 3'd0;
            st_next.phase      = i2cm_pkg::PH_RX_H;
          end
          i2cm_pkg::PH_RX_H: begin
            st_next.scl_reg = 1'b1;
            st_next.phase   = i2cm_pkg::PH_RX_L;
          end
          i2cm_pkg::PH_RX_L: begin
            st_next.scl_reg = 1'b0;
            if (item.sda_sample) begin
              st_next.shift_byte[bit_pos] = 1'b1;
            end
            if (st.bit_index == 3'd7) begin
              st_next.bytes_left = st.bytes_left - 8'd1;
              rd_valid           = 1'b1;
              st_next.phase      = i2cm_pkg::PH_MA_D;
            end else begin
              st_next.bit_index = st.bit_index + 3'd1;
              st_next.phase     = i2cm_pkg::PH_RX_H;
            end
          end
          i2cm_pkg::PH_MA_D: begin
            st_next.sda_reg = (st.bytes_left == 8'd0);
            st_next.phase   = i2cm_pkg::PH_MA_H;
          end
          i2cm_pkg::PH_MA_H: begin
            st_next.scl_reg = 1'b1;
            st_next.phase   = i2cm_pkg::PH_MA_L;
          end
          i2cm_pkg::PH_MA_L: begin
            st_next.scl_reg = 1'b0;
            st_next.phase   = (st.bytes_left == 8'd0) ? i2cm_pkg::PH_SP0
                                                      : i2cm_pkg::PH_RX_R;
          end
          i2cm_pkg::PH_SP0: begin
            st_next.sda_reg = 1'b0;
            st_next.phase   = i2cm_pkg::PH_SP1;
          end
          i2cm_pkg::PH_SP1: begin
            st_next.scl_reg = 1'b1;
            st_next.phase   = i2cm_pkg::PH_SP2;
          end
          i2cm_pkg::PH_SP2: begin
            st_next.sda_reg = 1'b1;
            stop_done       = 1'b1;
            st_next.phase   = i2cm_pkg::PH_IDLE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.scl_level    = st_next.scl_reg;
    result.sda_level    = st_next.sda_reg;
    result.read_data    = rd_valid ? st_next.shift_byte : 8'd0;
    result.read_valid   = rd_valid;
    result.data_request = (st_next.phase == i2cm_pkg::PH_WAIT);
    result.ack_level    = st_next.ack_reg;
    result.busy_res     = (st_next.phase != i2cm_pkg::PH_IDLE);
    result.done_res     = stop_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= i2cm_pkg::PH_IDLE;
      st.op_kind       <= i2cm_pkg::KIND_SREAD;
      st.bit_index     <= 3'd0;
      st.shift_byte    <= 8'd0;
      st.bytes_left    <= 8'd0;
      st.held_dev_addr <= 8'd0;
      st.held_reg_addr <= 8'd0;
      st.scl_reg       <= 1'b1;
      st.sda_reg       <= 1'b1;
      st.seg           <= i2cm_pkg::SEG_DEV;
      st.ack_reg       <= 1'b1;
    end else if (step_en) begin
      st <= st_next;
    end
  end

endmodule

// ----- hw/rtl/i2c_register_master_top.sv -----
// ----------------------------------------------------------------------------
// i2c_register_master_top
// I2C register read/write master, one SCL or SDA pin step per tick command.
//
//   channel  direction  handshake              payload
//   cmd      in         cmd_valid / cmd_stall  i2cm_pkg::cmd_t
//   rsp      out        rsp_valid / rsp_stall  i2cm_pkg::rsp_t
//
// one transfer in and one transfer out per cycle when neither side stalls
// the path has two registers: input register, then sequencer step into the result
// register; the sequencer state register loads with the result and sets the rate
// synchronous reset returns the bus to released (scl and sda high), idle
// a stalled result holds the step logic; the input register then stalls cmd
// ----------------------------------------------------------------------------
module i2c_register_master_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  i2cm_pkg::cmd_t  cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output i2cm_pkg::rsp_t  rsp
);

  logic           in_full;
  i2cm_pkg::cmd_t in_item;
  logic           advance;
  i2cm_pkg::rsp_t step_rsp;

  assign advance   = in_full && (!rsp_valid || !rsp_stall);
  assign cmd_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      in_item <= cmd;
    end
  end

  i2cm_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (in_item),
    .result  (step_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= step_rsp;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.done_res |-> !rsp.busy_res)
    else $error("stop completed while still busy");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.read_valid || rsp.data_request) |-> rsp.busy_res)
    else $error("read byte or data request outside a transaction");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled without a stalled result");

  a_step_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("sequencer step lost its result");

endmodule

// ----- tb/i2cm_bus_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_bus_checker
// Watches both channels of the I2C register master. Every accepted command
// advances a local copy of the sequencer and queues the pin levels and status
// it should produce; every accepted result is compared field by field with the
// oldest queued entry. Mismatches and entries still queued go to the top.
// ----------------------------------------------------------------------------
module i2cm_bus_checker
  import i2cm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_stall,
  input  cmd_t cmd,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);

  seq_state_t master;
  rsp_t       levels_due[$];

  // one pin step of the sequencer for one accepted command
  function automatic rsp_t step_bus(input cmd_t c);
    rsp_t       r;
    logic [7:0] tx;
    logic [2:0] bi;
    logic       got_byte;
    logic       stopped;
    got_byte = 1'b0;
    stopped  = 1'b0;
    bi = master.bit_index;
    case (master.seg)
      SEG_DEV:  tx = master.held_dev_addr;
      SEG_REG:  tx = master.held_reg_addr;
      SEG_DATA: tx = master.shift_byte;
      default:  tx = master.held_dev_addr | READ_BIT;
    endcase
    case (c.opcode)
      OP_SREAD, OP_SWRITE, OP_BWRITE, OP_BREAD: begin
        if (master.phase == PH_IDLE) begin
          master.op_kind       = kind_t'(c.opcode[1:0] - 2'd1);
          master.held_dev_addr = c.dev_addr;
          master.held_reg_addr = c.reg_addr;
          master.shift_byte    = (c.opcode == OP_SWRITE) ? c.data_byte : 8'h00;
          master.bytes_left    = (c.opcode == OP_SREAD || c.opcode == OP_SWRITE) ?
                                 8'd1 : c.byte_count;
          master.seg           = SEG_DEV;
          master.bit_index     = 3'd0;
          master.phase         = PH_ST0;
        end
      end
      OP_SUPPLY: begin
        if (master.phase == PH_WAIT) begin
          master.shift_byte = c.data_byte;
          master.bytes_left = master.bytes_left - 8'd1;
          master.seg        = SEG_DATA;
          master.bit_index  = 3'd0;
          master.phase      = PH_TX_D;
        end
      end
      OP_TICK: begin
        case (master.phase)
          PH_ST0: begin
            master.sda_reg = 1'b1;
            master.phase   = PH_ST1;
          end
          PH_ST1: begin
            master.scl_reg = 1'b1;
            master.phase   = PH_ST2;
          end
          PH_ST2: begin
            master.sda_reg = 1'b0;
            master.phase   = PH_ST3;
          end
          PH_ST3: begin
            master.scl_reg   = 1'b0;
            master.bit_index = 3'd0;
            master.phase     = PH_TX_D;
          end
          PH_TX_D: begin
            master.sda_reg = tx[3'd7 - bi];
            master.phase   = PH_TX_H;
          end
          PH_TX_H: begin
            master.scl_reg = 1'b1;
            master.phase   = PH_TX_L;
          end
          PH_TX_L: begin
            master.scl_reg = 1'b0;
            if (bi == 3'd7) begin
              master.phase = PH_AK_D;
            end else begin
              master.bit_index = bi + 3'd1;
              master.phase     = PH_TX_D;
            end
          end
          PH_AK_D: begin
            master.sda_reg = 1'b1;
            master.phase   = PH_AK_H;
          end
          PH_AK_H: begin
            master.scl_reg = 1'b1;
            master.phase   = PH_AK_L;
          end
          PH_AK_L: begin
            master.scl_reg = 1'b0;
            master.ack_reg = c.sda_sample;
            if (master.seg == SEG_DEV) begin
              master.seg       = SEG_REG;
              master.bit_index = 3'd0;
              master.phase     = PH_TX_D;
            end else if (master.seg == SEG_RDEV) begin
              master.phase = (master.bytes_left == 8'd0) ? PH_SP0 : PH_RX_R;
            end else if (master.seg == SEG_REG &&
                         (master.op_kind == KIND_SREAD || master.op_kind == KIND_BREAD)) begin
              // repeated start for the read phase
              master.seg   = SEG_RDEV;
              master.phase = PH_ST0;
            end else if (master.bytes_left == 8'd0) begin
              master.phase = PH_SP0;
            end else if (master.op_kind == KIND_BWRITE) begin
              master.phase = PH_WAIT;
            end else begin
              master.bytes_left = master.bytes_left - 8'd1;
              master.seg        = SEG_DATA;
              master.bit_index  = 3'd0;
              master.phase      = PH_TX_D;
            end
          end
          PH_RX_R: begin
            master.sda_reg    = 1'b1;
            master.shift_byte = 8'h00;
            master.bit_index  = 3'd0;
            master.phase      = PH_RX_H;
          end
          PH_RX_H: begin
            master.scl_reg = 1'b1;
            master.phase   = PH_RX_L;
          end
          PH_RX_L: begin
            master.scl_reg = 1'b0;
            if (c.sda_sample) master.shift_byte[3'd7 - bi] = 1'b1;
            if (bi == 3'd7) begin
              master.bytes_left = master.bytes_left - 8'd1;
              got_byte          = 1'b1;
              master.phase      = PH_MA_D;
            end else begin
              master.bit_index = bi + 3'd1;
              master.phase     = PH_RX_H;
            end
          end
          PH_MA_D: begin
            // nack after the last byte
            master.sda_reg = (master.bytes_left == 8'd0);
            master.phase   = PH_MA_H;
          end
          PH_MA_H: begin
            master.scl_reg = 1'b1;
            master.phase   = PH_MA_L;
          end
          PH_MA_L: begin
            master.scl_reg = 1'b0;
            master.phase   = (master.bytes_left == 8'd0) ? PH_SP0 : PH_RX_R;
          end
          PH_SP0: begin
            master.sda_reg = 1'b0;
            master.phase   = PH_SP1;
          end
          PH_SP1: begin
            master.scl_reg = 1'b1;
            master.phase   = PH_SP2;
          end
          PH_SP2: begin
            master.sda_reg = 1'b1;
            stopped        = 1'b1;
            master.phase   = PH_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.scl_level    = master.scl_reg;
    r.sda_level    = master.sda_reg;
    r.read_data    = got_byte ? master.shift_byte : 8'h00;
    r.read_valid   = got_byte;
    r.data_request = (master.phase == PH_WAIT);
    r.ack_level    = master.ack_reg;
    r.busy_res     = (master.phase != PH_IDLE);
    r.done_res     = stopped;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      master         = '0;
      master.phase   = PH_IDLE;
      master.scl_reg = 1'b1;
      master.sda_reg = 1'b1;
      master.ack_reg = 1'b1;
      levels_due.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (levels_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("rsp transfer with nothing expected: %h", rsp);
        end else begin
          want = levels_due.pop_front();
          if (rsp.scl_level !== want.scl_level || rsp.sda_level !== want.sda_level ||
              rsp.read_data !== want.read_data || rsp.read_valid !== want.read_valid ||
              rsp.data_request !== want.data_request || rsp.ack_level !== want.ack_level ||
              rsp.busy_res !== want.busy_res || rsp.done_res !== want.done_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("rsp mismatch:   scl sda data valid req ack busy done");
              $display("  expected       %b   %b  %h    %b    %b   %b    %b    %b",
                       want.scl_level, want.sda_level, want.read_data, want.read_valid,
                       want.data_request, want.ack_level, want.busy_res, want.done_res);
              $display("  actual         %b   %b  %h    %b    %b   %b    %b    %b",
                       rsp.scl_level, rsp.sda_level, rsp.read_data, rsp.read_valid,
                       rsp.data_request, rsp.ack_level, rsp.busy_res, rsp.done_res);
            end
          end
        end
      end
      if (cmd_valid && !cmd_stall) levels_due.push_back(step_bus(cmd));
      outstanding = levels_due.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the I2C register master with complete read and write transactions
// paced by tick commands, mixed with commands the block must ignore, under
// random idling on both channels, a long result hold-off and a full drain.
// The checker beside the block predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cm_pkg::*;

  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;

  // tick counts of the bus segments
  localparam int STEPS_START   = 4;
  localparam int STEPS_BYTE    = 27;
  localparam int STEPS_RX_BYTE = 20;
  localparam int STEPS_STOP    = 3;

  localparam int ITEMS        = 450;
  localparam int HOLD_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 2000;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   mismatches;
  int   outstanding;

  int   send_idle_pct = 18;
  int   recv_idle_pct = 52;
  bit   hold_off_req  = 1'b0;
  bit   swapped       = 1'b0;
  int   items_done;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  i2c_register_master_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  i2cm_bus_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic cmd_t random_cmd(input logic [2:0] op);
    cmd_t c;
    c = {$urandom, 4'($urandom)};
    c.opcode = op;
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    items_done++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // idling schedule by items sent so far
  task automatic pace();
    if (!swapped && items_done >= ITEMS / 3) begin
      drain_results();
      swapped       = 1'b1;
      send_idle_pct = 52;
      recv_idle_pct = 18;
    end
    if (items_done >= 2 * ITEMS / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // ticks with ignored commands slipped in while the bus is busy
  task automatic tick_run(input int n);
    repeat (n) begin
      if ($urandom_range(99) < 6)
        send_item(random_cmd(3'($urandom_range(OP_SUPPLY, OP_SREAD))));
      send_item(random_cmd(OP_TICK));
    end
  endtask

  task automatic run_transfer(input cmd_t c, input bit poke);
    send_item(c);
    if (poke) begin
      for (int k = OP_SREAD; k <= OP_SUPPLY; k++) send_item(random_cmd(k[2:0]));
    end
    case (c.opcode)
      OP_SWRITE: tick_run(STEPS_START + 3 * STEPS_BYTE + STEPS_STOP);
      OP_SREAD:  tick_run(2 * STEPS_START + 3 * STEPS_BYTE + STEPS_RX_BYTE + STEPS_STOP);
      OP_BREAD:  tick_run(2 * STEPS_START + 3 * STEPS_BYTE + c.byte_count * STEPS_RX_BYTE +
                          STEPS_STOP);
      default: begin
        tick_run(STEPS_START + 2 * STEPS_BYTE);
        repeat (c.byte_count) begin
          // data request pending
          if (poke || $urandom_range(3) == 0) begin
            send_item(random_cmd(OP_TICK));
            send_item(random_cmd(3'($urandom_range(OP_BREAD, OP_SREAD))));
          end
          send_item(random_cmd(OP_SUPPLY));
          tick_run(STEPS_BYTE);
        end
        tick_run(STEPS_STOP);
      end
    endcase
  endtask

  initial begin : receiver
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    cmd_t c;
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    items_done = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle bus: tick, stray supply, unused opcodes
    c = '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
    send_item(c);
    c = '{OP_SUPPLY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1};
    send_item(c);
    c.opcode = OP_UNUSED_A;
    send_item(c);
    c.opcode = OP_UNUSED_B;
    send_item(c);

    hold_off_req = 1'b1;
    c = '{OP_SWRITE, 8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1};
    run_transfer(c, 1'b1);
    pace();
    c = random_cmd(OP_BWRITE);
    c.byte_count = 8'h02;
    run_transfer(c, 1'b1);
    pace();
    c = '{OP_BREAD, 8'h00, 8'hFF, 8'h00, 8'h02, 1'b0};
    run_transfer(c, 1'b0);
    pace();
    c = random_cmd(OP_BWRITE);
    c.byte_count = 8'h00;
    run_transfer(c, 1'b0);
    pace();

    while (items_done < ITEMS) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(3, 1))
          send_item(random_cmd($urandom_range(1) ? OP_SUPPLY : OP_TICK));
      end else begin
        c = random_cmd(3'($urandom_range(OP_BREAD, OP_SREAD)));
        if (c.opcode == OP_BWRITE || c.opcode == OP_BREAD)
          c.byte_count = ($urandom_range(9) == 0) ? 8'($urandom_range(12, 4)) :
                                                   8'($urandom_range(3, 0));
        run_transfer(c, 1'b0);
      end
      pace();
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
